FILE: design/hcd_pkg.sv
package hcd_pkg;

    localparam int COUNT_W    = 31;     // hour count field
    localparam int CNT_W      = 5;      // step counter, holds COUNT_W - 1
    localparam int CHAR_W     = 6;      // ASCII digit field
    localparam int BCD_DIGITS = 4;      // year kept modulo 10000
    localparam int DAY_HOURS  = 24;
    localparam int YEAR_HOURS = 8760;   // 365 * 24
    localparam int YREM_W     = 14;     // remainder of count / YEAR_HOURS
    localparam int HOUR_W     = 5;      // remainder of / DAY_HOURS
    localparam int YDAY_W     = 9;      // day of year 0..364
    localparam int MONTH_W    = 4;      // month index 0..11
    localparam int MDAY_W     = 5;

    localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;

    typedef logic [3:0]        t_bcd;
    typedef logic [CHAR_W-1:0] t_char;

    typedef struct packed {
        t_bcd tens;
        t_bcd ones;
    } t_two_digit;

    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] idx);
        logic [4:0] len;
        unique case (idx)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic t_char to_char(input t_bcd d);
        return ASCII_ZERO + {2'b00, d};
    endfunction

    // 5-bit value (0..31) into two decimal digits
    function automatic t_two_digit split2(input logic [4:0] v);
        t_two_digit r;
        logic [4:0] low;
        priority if (v >= 5'd30) begin
            r.tens = 4'd3;
            low    = v - 5'd30;
        end else if (v >= 5'd20) begin
            r.tens = 4'd2;
            low    = v - 5'd20;
        end else if (v >= 5'd10) begin
            r.tens = 4'd1;
            low    = v - 5'd10;
        end else begin
            r.tens = 4'd0;
            low    = v;
        end
        r.ones = low[3:0];
        return r;
    endfunction

endpackage

FILE: design/hcd_if.sv
interface hcd_in_if;
    import hcd_pkg::*;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] hour_count;

    modport source (output valid, output hour_count, input ready);
    modport sink   (input valid, input hour_count, output ready);
endinterface

interface hcd_out_if;
    import hcd_pkg::*;
    logic  valid;
    logic  ready;
    t_char year_thousands;
    t_char year_hundreds;
    t_char year_tens;
    t_char year_ones;
    t_char month_tens;
    t_char month_ones;
    t_char day_tens;
    t_char day_ones;
    t_char hour_tens;
    t_char hour_ones;

    modport source (output valid, input ready,
                    output year_thousands, year_hundreds, year_tens, year_ones,
                    output month_tens, month_ones, day_tens, day_ones,
                    output hour_tens, hour_ones);
    modport sink   (input valid, output ready,
                    input year_thousands, year_hundreds, year_tens, year_ones,
                    input month_tens, month_ones, day_tens, day_ones,
                    input hour_tens, hour_ones);
endinterface

FILE: design/hcd_div_serial.sv
// Restoring divider by a constant, one dividend bit per cycle while i_shift is high, MSB first.
module hcd_div_serial #(
    parameter int DIVISOR = 24
) (
    input  logic                         i_clk,
    input  logic                         i_clear,
    input  logic                         i_shift,
    input  logic                         i_bit,
    output logic                         o_qbit,
    output logic [$clog2(DIVISOR)-1:0]   o_rem
);
    localparam int REM_W = $clog2(DIVISOR);
    localparam logic [REM_W:0] DIV_C = (REM_W + 1)'(DIVISOR);

    logic [REM_W-1:0] r_rem;
    logic [REM_W:0]   w_trial;
    logic [REM_W:0]   w_diff;

    assign w_trial = {r_rem, i_bit};
    assign w_diff  = w_trial - DIV_C;
    assign o_qbit  = (w_trial >= DIV_C);
    assign o_rem   = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_rem <= '0;
        end else if (i_shift) begin
            r_rem <= o_qbit ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
        end
    end
endmodule

FILE: design/hcd_bcd_serial.sv
// Shift-add-3 binary to BCD, one bit per cycle while i_shift is high;
// carries out of the top digit are dropped, so the digits track the value modulo 10000.
module hcd_bcd_serial (
    input  logic                    i_clk,
    input  logic                    i_clear,
    input  logic                    i_shift,
    input  logic                    i_bit,
    output hcd_pkg::t_bcd [3:0]     o_digits
);
    import hcd_pkg::*;

    t_bcd [BCD_DIGITS-1:0]   r_digits;
    t_bcd [BCD_DIGITS-1:0]   w_adj;
    logic [4*BCD_DIGITS:0]   w_shift;   // top bit is the dropped carry

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            w_adj[i] = (r_digits[i] >= 4'd5) ? r_digits[i] + 4'd3 : r_digits[i];
        end
    end

    assign w_shift = {w_adj, i_bit};

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_digits <= '0;
        end else if (i_shift) begin
            r_digits <= w_shift[4*BCD_DIGITS-1:0];
        end
    end

    assign o_digits = r_digits;
endmodule

FILE: design/hcd_month_walk.sv
// Walks the day of year through the month lengths, one month per cycle.
module hcd_month_walk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hcd_pkg::YDAY_W-1:0]    i_yday,
    output logic                          o_busy,
    output logic [hcd_pkg::MONTH_W-1:0]   o_month_idx,
    output logic [hcd_pkg::YDAY_W-1:0]    o_yday
);
    import hcd_pkg::*;

    logic                r_busy;
    logic [MONTH_W-1:0]  r_month;
    logic [YDAY_W-1:0]   r_yday;
    logic [YDAY_W-1:0]   w_len;
    logic                w_skip;

    assign w_len  = {{(YDAY_W - 5){1'b0}}, month_len(r_month)};
    assign w_skip = (r_month < LAST_MONTH) && (r_yday >= w_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && !w_skip) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_month <= '0;
            r_yday  <= i_yday;
        end else if (r_busy && w_skip) begin
            r_month <= r_month + 4'd1;
            r_yday  <= r_yday - w_len;
        end
    end

    assign o_busy      = r_busy;
    assign o_month_idx = r_month;
    assign o_yday      = r_yday;
endmodule

FILE: design/hour_count_to_calendar_digits.sv
// Hour count to calendar digits (no leap years).
//
// Input channel i_in carries a 31-bit elapsed-hour count; output channel
// o_out carries one timestamp per input: four year digits (year modulo
// 10000), two month, two day-of-month and two hour-of-day digits, each an
// ASCII character '0'..'9'. Both channels use valid/ready; a transaction
// happens on a clock edge where both are high.
//
// After the input transaction the count is shifted MSB first through two
// serial dividers (by 8760 for the year, by 24 for the hour) while the year
// quotient bits feed a serial BCD converter; the year remainder is then
// divided by 24 to get the day of year, and the month walk steps past one
// month per cycle. One count is in flight at a time: i_in.ready is high
// only while the sequencer is idle.
//
// The result sits in an output register, so a new count is taken while the
// previous result waits. If o_out.ready stays low the finished conversion
// holds in its last state until the register frees up. Synchronous reset
// returns the sequencer to idle and drops o_out.valid.
module hour_count_to_calendar_digits (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcd_in_if.sink     i_in,
    hcd_out_if.source  o_out
);
    import hcd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_A,    // count / 8760 and count % 24, year to BCD
        S_MID,      // capture hour, reload year remainder
        S_DIV_B,    // year remainder / 24 -> day of year
        S_WSTART,
        S_WAIT      // month walk, then hand off to output register
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [COUNT_W-1:0]  r_count;   // serial source, MSB out first
    logic [YDAY_W-1:0]   r_yday;
    logic [HOUR_W-1:0]   r_hour;
    logic                r_out_valid;
    t_char               r_y3, r_y2, r_y1, r_y0;
    t_char               r_mo_t, r_mo_o, r_d_t, r_d_o, r_h_t, r_h_o;

    logic                w_accept;
    logic                w_out_free;
    logic                w_load;
    logic                w_in_bit;
    logic                w_qbit_y;
    logic                w_qbit_h;
    logic [YREM_W-1:0]   w_rem_y;
    logic [HOUR_W-1:0]   w_rem_h;
    t_bcd [3:0]          w_year;
    logic                w_walk_busy;
    logic [MONTH_W-1:0]  w_month_idx;
    logic [YDAY_W-1:0]   w_walk_yday;
    t_two_digit          w_month_dd, w_mday_dd, w_hour_dd;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in_bit   = r_count[COUNT_W-1];
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_load     = (r_state == S_WAIT) && !w_walk_busy && w_out_free;

    hcd_div_serial #(.DIVISOR(8760)) u_div_year (
        .i_clk   (i_clk),
        .i_clear (w_accept),
        .i_shift (r_state == S_DIV_A),
        .i_bit   (w_in_bit),
        .o_qbit  (w_qbit_y),
        .o_rem   (w_rem_y)
    );

    // shared: hour of day in the first pass, day of year in the second
    hcd_div_serial #(.DIVISOR(24)) u_div_hour (
        .i_clk   (i_clk),
        .i_clear (w_accept || (r_state == S_MID)),
        .i_shift ((r_state == S_DIV_A) || (r_state == S_DIV_B)),
        .i_bit   (w_in_bit),
        .o_qbit  (w_qbit_h),
        .o_rem   (w_rem_h)
    );

    hcd_bcd_serial u_bcd (
        .i_clk    (i_clk),
        .i_clear  (w_accept),
        .i_shift  (r_state == S_DIV_A),
        .i_bit    (w_qbit_y),
        .o_digits (w_year)
    );

    hcd_month_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_WSTART),
        .i_yday      (r_yday),
        .o_busy      (w_walk_busy),
        .o_month_idx (w_month_idx),
        .o_yday      (w_walk_yday)
    );

    assign w_month_dd = split2({1'b0, w_month_idx} + 5'd1);
    assign w_mday_dd  = split2(w_walk_yday[MDAY_W-1:0] + 5'd1);
    assign w_hour_dd  = split2(r_hour);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a new result may replace one taken at this same edge
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count <= i_in.hour_count;
                        r_cnt   <= '0;
                        r_state <= S_DIV_A;
                    end
                end
                S_DIV_A: begin
                    r_count <= r_count << 1;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(COUNT_W - 1)) begin
                        r_state <= S_MID;
                    end
                end
                S_MID: begin
                    r_hour  <= w_rem_h;
                    r_count <= {w_rem_y, {(COUNT_W - YREM_W){1'b0}}};
                    r_yday  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV_B;
                end
                S_DIV_B: begin
                    r_count <= r_count << 1;
                    r_yday  <= {r_yday[YDAY_W-2:0], w_qbit_h};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(YREM_W - 1)) begin
                        r_state <= S_WSTART;
                    end
                end
                S_WSTART: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_load) begin
                        r_y3        <= to_char(w_year[3]);
                        r_y2        <= to_char(w_year[2]);
                        r_y1        <= to_char(w_year[1]);
                        r_y0        <= to_char(w_year[0]);
                        r_mo_t      <= to_char(w_month_dd.tens);
                        r_mo_o      <= to_char(w_month_dd.ones);
                        r_d_t       <= to_char(w_mday_dd.tens);
                        r_d_o       <= to_char(w_mday_dd.ones);
                        r_h_t       <= to_char(w_hour_dd.tens);
                        r_h_o       <= to_char(w_hour_dd.ones);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.year_thousands = r_y3;
    assign o_out.year_hundreds  = r_y2;
    assign o_out.year_tens      = r_y1;
    assign o_out.year_ones      = r_y0;
    assign o_out.month_tens     = r_mo_t;
    assign o_out.month_ones     = r_mo_o;
    assign o_out.day_tens       = r_d_t;
    assign o_out.day_ones       = r_d_o;
    assign o_out.hour_tens      = r_h_t;
    assign o_out.hour_ones      = r_h_o;

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_DIV_A)
        else $error("conversion did not start after input transaction");

    a_hour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT |-> r_hour < HOUR_W'(DAY_HOURS))
        else $error("hour remainder out of range");

    a_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT |-> w_month_idx <= LAST_MONTH)
        else $error("month walk ran past December");

    a_mday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_walk_yday < {{(YDAY_W - 5){1'b0}}, month_len(w_month_idx)})
        else $error("day of month exceeds month length");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_out.hour_tens <= ASCII_ZERO + 6'd2)
                     && (o_out.day_tens <= ASCII_ZERO + 6'd3)
                     && (o_out.month_tens <= ASCII_ZERO + 6'd1))
        else $error("output digit out of range");

endmodule

FILE: test/tb_hour_count_to_calendar_digits.sv
module tb_hour_count_to_calendar_digits;
    import hcd_pkg::*;

    // one timestamp, index 0 = year thousands ... index 9 = hour ones
    typedef t_char [0:9] t_stamp;

    // directed row: count and, where obvious, the timestamp as ASCII text
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [79:0]        digits;
    } t_row;

    localparam logic [79:0] FROM_MODEL   = '0;
    localparam int          N_DIRECTED   = 20;
    localparam int          N_RANDOM     = 650;
    localparam int          CALM_FIRST   = 250;
    localparam int          CALM_LAST    = 400;
    localparam int          DRAIN_PAUSE  = 500;
    localparam int          IDLE_PCT     = 6;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          LIMIT_TIME   = 1_200_000;
    localparam int unsigned HOURS_IN_DAY = 24;
    localparam int unsigned DAYS_IN_YEAR = 365;
    localparam int unsigned WRAP_HOURS   = 87_600_000;    // 10000 years
    localparam int unsigned MAX_COUNT    = 32'h7FFF_FFFF;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    bit     calm = 1'b0;
    int     mismatches = 0;
    t_stamp pending_stamps [$];
    t_row   directed_rows [N_DIRECTED];

    hcd_in_if  in_ch ();
    hcd_out_if out_ch ();

    hour_count_to_calendar_digits uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #LIMIT_TIME;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned days_in_month(input int unsigned m);
        case (m)
            1:           return 28;
            3, 5, 8, 10: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic int unsigned month_start(input int unsigned m);
        int unsigned sum;
        sum = 0;
        for (int unsigned k = 0; k < m; k++) sum += days_in_month(k);
        return sum;
    endfunction

    function automatic t_char ascii_digit(input int unsigned v);
        return ASCII_ZERO + t_char'(v % 10);
    endfunction

    function automatic t_stamp calendar_of(input logic [COUNT_W-1:0] cnt);
        int unsigned c, hour, days, year, yday, month, mday;
        t_stamp s;
        c    = cnt;
        hour = c % HOURS_IN_DAY;
        days = c / HOURS_IN_DAY;
        year = (days / DAYS_IN_YEAR) % 10000;
        yday = days % DAYS_IN_YEAR;
        month = 0;
        // skip a month while the day index reaches its length
        while (month < 11 && yday >= days_in_month(month)) begin
            yday -= days_in_month(month);
            month++;
        end
        month++;
        mday = yday + 1;
        s[0] = ascii_digit(year / 1000);
        s[1] = ascii_digit(year / 100);
        s[2] = ascii_digit(year / 10);
        s[3] = ascii_digit(year);
        s[4] = ascii_digit(month / 10);
        s[5] = ascii_digit(month);
        s[6] = ascii_digit(mday / 10);
        s[7] = ascii_digit(mday);
        s[8] = ascii_digit(hour / 10);
        s[9] = ascii_digit(hour);
        return s;
    endfunction

    function automatic t_stamp stamp_of_text(input logic [79:0] text);
        t_stamp s;
        for (int i = 0; i < 10; i++) s[i] = t_char'(text[79 - 8 * i -: 8]);
        return s;
    endfunction

    function automatic string field_name(input int i);
        case (i)
            0:       return "year_thousands";
            1:       return "year_hundreds";
            2:       return "year_tens";
            3:       return "year_ones";
            4:       return "month_tens";
            5:       return "month_ones";
            6:       return "day_tens";
            7:       return "day_ones";
            8:       return "hour_tens";
            default: return "hour_ones";
        endcase
    endfunction

    // mix of uniform counts, early years, and counts near month, day, wrap and max bounds
    function automatic logic [COUNT_W-1:0] random_count();
        longint unsigned v;
        int unsigned kind, yr, m;
        kind = $urandom_range(99);
        if (kind < 40) begin
            v = $urandom & MAX_COUNT;
        end else if (kind < 60) begin
            yr = $urandom_range(0, 245145);
            m  = $urandom_range(1, 11);
            v  = (longint'(yr) * DAYS_IN_YEAR + month_start(m) - $urandom_range(0, 1))
                 * HOURS_IN_DAY + $urandom_range(0, 23);
        end else if (kind < 75) begin
            v = $urandom_range(0, 3 * 8760 - 1);
        end else if (kind < 85) begin
            v = longint'($urandom_range(1, 24)) * WRAP_HOURS
                + longint'($urandom_range(0, 96)) - 48;
        end else if (kind < 90) begin
            v = MAX_COUNT - $urandom_range(0, 2000);
        end else begin
            v = longint'($urandom_range(0, 89478484)) * HOURS_IN_DAY
                + ($urandom_range(1) ? 0 : 23);
        end
        return v[COUNT_W-1:0];
    endfunction

    // presents one count from a falling edge, returns at the accepting edge
    task automatic offer_count(input logic [COUNT_W-1:0] cnt, input t_stamp want);
        @(negedge clk);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid      <= 1'b0;
            in_ch.hour_count <= COUNT_W'($urandom);
            repeat ($urandom_range(1, 64)) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.hour_count <= cnt;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        pending_stamps.push_back(want);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_stamps.size() != 0) @(posedge clk);
    endtask

    // result side: random back-pressure, none during the calm stretch
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // result checker, sampled at the rising edge
    always @(posedge clk) begin : result_check
        t_stamp got, want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.year_thousands, out_ch.year_hundreds, out_ch.year_tens,
                   out_ch.year_ones, out_ch.month_tens, out_ch.month_ones,
                   out_ch.day_tens, out_ch.day_ones, out_ch.hour_tens,
                   out_ch.hour_ones};
            if (pending_stamps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no pending count: %h", got);
            end else begin
                want = pending_stamps.pop_front();
                for (int i = 0; i < 10; i++) begin
                    if (got[i] !== want[i]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch %s: expected %0d actual %0d",
                                     field_name(i), want[i], got[i]);
                    end
                end
            end
        end
    end

    initial begin
        logic [COUNT_W-1:0] cnt;

        // obvious rows carry their timestamp; the rest go through the predictor
        directed_rows = '{
            '{31'd0,          "0000010100"},   // epoch
            '{31'd23,         "0000010123"},   // last hour of the first day
            '{31'd24,         "0000010200"},
            '{31'd720,        "0000013100"},   // last day of January
            '{31'd744,        "0000020100"},
            '{31'd1392,       "0000022800"},   // last day of February
            '{31'd1416,       "0000030100"},
            '{31'd8759,       "0000123123"},   // last hour of a year
            '{31'd8760,       "0001010100"},
            '{31'd87599999,   "9999123123"},   // last hour before year wraps
            '{31'd87600000,   "0000010100"},   // year wraps to zero
            '{31'h7FFFFFFF,   "5146071507"},   // largest count
            '{31'd4332,       FROM_MODEL},     // June 30, hour 12
            '{31'd4344,       FROM_MODEL},     // July 1
            '{31'd5064,       FROM_MODEL},     // July 31
            '{31'd7995,       FROM_MODEL},     // November 30
            '{31'd8021,       FROM_MODEL},     // December 1
            '{31'h55555555,   FROM_MODEL},
            '{31'h2AAAAAAA,   FROM_MODEL},
            '{31'd10812253,   FROM_MODEL}      // year 1234, April 11
        };

        in_ch.valid      = 1'b0;
        in_ch.hour_count = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            cnt = directed_rows[r].count;
            offer_count(cnt, (directed_rows[r].digits == FROM_MODEL) ?
                             calendar_of(cnt) : stamp_of_text(directed_rows[r].digits));
        end
        wait_for_drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            if (n == DRAIN_PAUSE) wait_for_drain();
            cnt = random_count();
            offer_count(cnt, calendar_of(cnt));
        end
        calm = 1'b0;

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_stamps.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
